@@ sv/ovs_pkg.sv @@
`timescale 1ns / 1ps

package ovs_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_CAPACITY    = 32;
	localparam int DEF_VALUE_WIDTH = 32;

	// Fixed field widths of the request and result channels
	localparam int CMD_W       = 2;
	localparam int VALUE_IN_W  = 32;
	localparam int COUNT_OUT_W = 6;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load_req;   // latch request, clear pointer and flags
		logic rd_scan;    // read entry at pointer
		logic rd_next;    // read entry at pointer + 1
		logic ptr_inc;    // advance pointer
		logic wr_append;  // write request value at end of list
		logic wr_shift;   // write read data at pointer
		logic cnt_inc;
		logic cnt_dec;
		logic set_ok;     // success flag
		logic set_rej;    // rejected-full flag
		logic load_out;   // move result into output register
	} ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic             at_end;    // pointer equals live count
		logic             next_end;  // pointer + 1 equals live count
		logic             match;     // read data equals request value
		logic             full;
		logic             out_free;  // output register can take a result
	} sts_t;

endpackage

@@ sv/ovs_if.sv @@
`timescale 1ns / 1ps

// Request channel: one command and value per request
interface ovs_req_if;
	logic                              valid;
	logic                              ready;
	logic [ovs_pkg::CMD_W-1:0]         cmd;
	logic signed [ovs_pkg::VALUE_IN_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

// Result channel: one result per request
interface ovs_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              success;
	logic [ovs_pkg::COUNT_OUT_W-1:0]   member_count;
	logic                              is_empty;
	logic                              rejected_full;

	modport source (output valid, output success, output member_count,
		output is_empty, output rejected_full, input ready);
	modport sink   (input valid, input success, input member_count,
		input is_empty, input rejected_full, output ready);
endinterface

@@ sv/ovs_ctrl.sv @@
`timescale 1ns / 1ps

module ovs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  ovs_pkg::sts_t  sts,
	output ovs_pkg::ctl_t  ctl
);

	typedef enum logic [6:0] {
		S_IDLE     = 7'b0000001,
		S_SCAN_RD  = 7'b0000010,
		S_SCAN_CMP = 7'b0000100,
		S_DECIDE   = 7'b0001000,
		S_SHIFT_RD = 7'b0010000,
		S_SHIFT_WR = 7'b0100000,
		S_FINISH   = 7'b1000000
	} state_t;

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign req_ready = (state_q == S_IDLE);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					ctl.load_req = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				// pointer at live count: value absent
				if (sts.at_end) begin
					state_d = S_DECIDE;
				end else begin
					ctl.rd_scan = 1'b1;
					state_d     = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.match) begin
					state_d = S_DECIDE;
				end else begin
					ctl.ptr_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				// found exactly when the scan stopped short of the end
				state_d = S_FINISH;
				case (sts.op)
					ovs_pkg::CMD_ADD: begin
						if (sts.at_end) begin
							if (!sts.full) begin
								ctl.wr_append = 1'b1;
								ctl.cnt_inc   = 1'b1;
								ctl.set_ok    = 1'b1;
							end else begin
								ctl.set_rej = 1'b1;
							end
						end
					end
					ovs_pkg::CMD_REMOVE: begin
						if (!sts.at_end) begin
							state_d = S_SHIFT_RD;
						end
					end
					ovs_pkg::CMD_QUERY: begin
						ctl.set_ok = !sts.at_end;
					end
					default: begin
					end
				endcase
			end
			S_SHIFT_RD: begin
				// close the gap one entry at a time
				if (sts.next_end) begin
					ctl.cnt_dec = 1'b1;
					ctl.set_ok  = 1'b1;
					state_d     = S_FINISH;
				end else begin
					ctl.rd_next = 1'b1;
					state_d     = S_SHIFT_WR;
				end
			end
			S_SHIFT_WR: begin
				ctl.wr_shift = 1'b1;
				ctl.ptr_inc  = 1'b1;
				state_d      = S_SHIFT_RD;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					ctl.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ sv/ovs_dp.sv @@
`timescale 1ns / 1ps

module ovs_dp #(
	parameter int CAPACITY    = ovs_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = ovs_pkg::DEF_VALUE_WIDTH
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ovs_pkg::ctl_t                          ctl,
	output ovs_pkg::sts_t                          sts,
	input  logic [ovs_pkg::CMD_W-1:0]              req_cmd,
	input  logic signed [ovs_pkg::VALUE_IN_W-1:0]  req_value,
	output logic                                   rsp_valid,
	input  logic                                   rsp_ready,
	output logic                                   rsp_success,
	output logic [ovs_pkg::COUNT_OUT_W-1:0]        rsp_member_count,
	output logic                                   rsp_is_empty,
	output logic                                   rsp_rejected_full
);

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [VALUE_WIDTH-1:0]     mem [CAPACITY];
	logic [VALUE_WIDTH-1:0]     rd_data_q;
	logic [VALUE_WIDTH-1:0]     val_q;
	logic [ovs_pkg::CMD_W-1:0]  op_q;
	logic [CNT_W-1:0]           ptr_q;
	logic [CNT_W-1:0]           ptr_nx;
	logic [CNT_W-1:0]           count_q;
	logic                       ok_q;
	logic                       rej_q;
	logic                       out_valid_q;
	logic                       success_q;
	logic [ovs_pkg::COUNT_OUT_W-1:0] member_count_q;
	logic                       is_empty_q;
	logic                       rejected_full_q;
	logic [IDX_W-1:0]           rd_addr;
	logic [IDX_W-1:0]           wr_addr;
	logic [VALUE_WIDTH-1:0]     wr_data;

	assign ptr_nx = ptr_q + 1'b1;

	// Request latch, pointer and flags
	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			op_q  <= req_cmd;
			val_q <= VALUE_WIDTH'(req_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			count_q <= '0;
			ok_q    <= 1'b0;
			rej_q   <= 1'b0;
		end else begin
			if (ctl.load_req) begin
				ptr_q <= '0;
				ok_q  <= 1'b0;
				rej_q <= 1'b0;
			end else begin
				if (ctl.ptr_inc) ptr_q <= ptr_nx;
				if (ctl.set_ok)  ok_q  <= 1'b1;
				if (ctl.set_rej) rej_q <= 1'b1;
			end
			if (ctl.cnt_inc) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry store: one read port, one write port
	assign rd_addr = ctl.rd_next ? ptr_nx[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign wr_addr = ctl.wr_append ? count_q[IDX_W-1:0] : ptr_q[IDX_W-1:0];
	assign wr_data = ctl.wr_append ? val_q : rd_data_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_append || ctl.wr_shift) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_scan || ctl.rd_next) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			success_q       <= ok_q;
			member_count_q  <= ovs_pkg::COUNT_OUT_W'(count_q);
			is_empty_q      <= (count_q == '0);
			rejected_full_q <= rej_q;
		end
	end

	assign rsp_valid         = out_valid_q;
	assign rsp_success       = success_q;
	assign rsp_member_count  = member_count_q;
	assign rsp_is_empty      = is_empty_q;
	assign rsp_rejected_full = rejected_full_q;

	// Status
	assign sts.op       = op_q;
	assign sts.at_end   = (ptr_q == count_q);
	assign sts.next_end = (ptr_nx == count_q);
	assign sts.match    = (rd_data_q == val_q);
	assign sts.full     = (count_q == CNT_W'(CAPACITY));
	assign sts.out_free = !out_valid_q || rsp_ready;

endmodule

@@ sv/ordered_value_set.sv @@
`timescale 1ns / 1ps

// Bounded set of distinct values kept in insertion order with no gaps. Each
// request adds, removes or queries one value and yields exactly one result.
// Entries sit in a single-port-read, single-port-write memory; a controller
// walks it one entry at a time, reading it (S_SCAN_RD), then comparing it
// with the request value (S_SCAN_CMP). Removing the entry at slot s shifts
// each later live entry down one slot, reading it (S_SHIFT_RD) and writing
// it back (S_SHIFT_WR). One request is in work at a time; a new request
// is taken while the previous result still waits in the output register.
module ordered_value_set #(
	parameter int CAPACITY    = ovs_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = ovs_pkg::DEF_VALUE_WIDTH
) (
	input  logic      clk,
	input  logic      arst_n,
	ovs_req_if.sink   request,
	ovs_rsp_if.source result
);

	ovs_pkg::ctl_t ctl;
	ovs_pkg::sts_t sts;

	ovs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (request.valid),
		.req_ready (request.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	ovs_dp #(
		.CAPACITY    (CAPACITY),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.ctl               (ctl),
		.sts               (sts),
		.req_cmd           (request.cmd),
		.req_value         (request.value),
		.rsp_valid         (result.valid),
		.rsp_ready         (result.ready),
		.rsp_success       (result.success),
		.rsp_member_count  (result.member_count),
		.rsp_is_empty      (result.is_empty),
		.rsp_rejected_full (result.rejected_full)
	);

	// Accepted request leaves idle at once
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		request.valid && request.ready |=> !request.ready)
		else $error("ready stayed high after a request was taken");

	// Never append into a full store
	a_no_append_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.wr_append |-> !sts.full)
		else $error("append issued while full");

	// Rejection and success exclude each other
	a_rej_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.rejected_full |-> !result.success)
		else $error("result both rejected and successful");

	// Empty set reports a zero count
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.is_empty |-> result.member_count == '0)
		else $error("empty flag with nonzero count");

endmodule
